[rtl/twis_pkg.sv]
// Shared types for the two-way insertion sorter.
// Command and status groups between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package twis_pkg;

	// controller -> datapath
	typedef struct packed {
		logic classify;    // pick pivot/front/back, init search bounds
		logic search_rd;   // probe store at midpoint
		logic search_cmp;  // narrow bounds with probe word
		logic shift_init;
		logic shift_step;  // move one word one slot
		logic place;       // write new word, update region bounds
		logic emit_init;
		logic emit_step;   // read one word for output
		logic clear;       // end of run: empty the store
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;
		logic full;
		logic direct;       // no search needed (pivot or first front word)
		logic search_more;
		logic shift_more;
		logic emit_last;
	} stat_t;

endpackage

[rtl/two_way_insertion_sorter_unit.sv]
// Two-way insertion sorter, top level.
// Channels: input words are taken when start is high and busy is low; each
// word carries value and last_item. Results appear on sorted_value,
// end_of_run and overflow for one cycle each, marked by strobe; the
// receiver cannot stall, so every strobed word must be taken as shown.
// Per input word, the pivot or the first front word goes straight from
// classify to place; any other word takes binary-search probes (at most
// log2(DEPTH)+1 probes), then one shift step per shifted word, a flush
// and place, sequenced around the single read and single write port of
// the element store. A word arriving at a full store is dropped in the
// classify state. On a word with last_item set, the place state (or, at
// a full store, the classify state) is followed by emit setup and the emit
// states; results come from registered reads, one result per cycle, front
// region then back region, in ascending signed order; end_of_run marks the
// final result, overflow is high on all results of a set that dropped
// words beyond DEPTH. The store is then empty and busy falls in the cycle
// after the final strobe.
// Reset clears the region bounds, counts and flags; store contents are not
// cleared and need no clearing pass.
// Depends on twis_pkg, twis_ctrl, twis_dpath.
`timescale 1ns / 1ps

module two_way_insertion_sorter_unit #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic                  last_item,
	output logic                  strobe,
	output logic [DATA_WIDTH-1:0] sorted_value,
	output logic                  end_of_run,
	output logic                  overflow
);
	import twis_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  load;

	twis_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.load   (load),
		.stat   (stat),
		.cmd    (cmd)
	);

	twis_dpath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.value        (value),
		.last_item    (last_item),
		.cmd          (cmd),
		.stat         (stat),
		.strobe       (strobe),
		.sorted_value (sorted_value),
		.end_of_run   (end_of_run),
		.overflow     (overflow)
	);

endmodule

[rtl/twis_dpath.sv]
// Datapath of the two-way insertion sorter: element store, region bounds,
// binary search bounds, shift and output pointers.
// Depends on twis_pkg.
`timescale 1ns / 1ps

module twis_dpath #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [DATA_WIDTH-1:0]  value,
	input  logic                   last_item,
	input  twis_pkg::cmd_t         cmd,
	output twis_pkg::stat_t        stat,
	output logic                   strobe,
	output logic [DATA_WIDTH-1:0]  sorted_value,
	output logic                   end_of_run,
	output logic                   overflow
);
	import twis_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW = AW + 1;

	localparam logic [1:0] MODE_PIVOT = 2'd0;
	localparam logic [1:0] MODE_FIRST = 2'd1;
	localparam logic [1:0] MODE_FRONT = 2'd2;
	localparam logic [1:0] MODE_BACK  = 2'd3;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;
	logic [DATA_WIDTH-1:0] v_q;
	logic [DATA_WIDTH-1:0] pivot_q;
	logic                  last_q;
	logic [1:0]            mode_q;
	logic [AW-1:0]         fs_q;
	logic [AW-1:0]         be_q;
	logic [IW-1:0]         cnt_q;
	logic                  ovf_q;
	logic [IW-1:0]         lo_q;
	logic [IW-1:0]         hi_q;
	logic [IW-1:0]         mid_q;
	logic [IW-1:0]         sptr_q;
	logic                  pend_q;
	logic [AW-1:0]         pwa_q;
	logic [AW-1:0]         eptr_q;
	logic                  efront_q;
	logic                  out_vld_s1;
	logic                  out_end_s1;

	logic [IW:0]           mid_sum;
	logic [IW-1:0]         mid;
	logic                  is_front;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic [AW-1:0]         target;

	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[IW:1];
	assign is_front = $signed(v_q) < $signed(pivot_q);

	assign stat.last        = last_q;
	assign stat.full        = cnt_q >= IW'(DEPTH);
	assign stat.direct      = (cnt_q == '0) || (is_front && fs_q == '0);
	assign stat.search_more = lo_q <= hi_q;
	assign stat.shift_more  = (mode_q == MODE_FRONT) ? (sptr_q <= hi_q) : (sptr_q >= lo_q);
	assign stat.emit_last   = !efront_q && (eptr_q == be_q);

	always_comb begin
		unique case (mode_q)
			MODE_PIVOT: target = '0;
			MODE_FIRST: target = AW'(DEPTH - 1);
			MODE_FRONT: target = hi_q[AW-1:0];
			MODE_BACK:  target = lo_q[AW-1:0];
			default:    target = '0;
		endcase
	end

	// one read port: search probe, shift source or output word
	always_comb begin
		rd_en   = cmd.search_rd | cmd.shift_step | cmd.emit_step;
		rd_addr = eptr_q;
		if (cmd.search_rd) begin
			rd_addr = mid[AW-1:0];
		end else if (cmd.shift_step) begin
			rd_addr = sptr_q[AW-1:0];
		end
	end

	// one write port: pending shifted word first, then the new word
	always_comb begin
		wr_en   = pend_q | cmd.place;
		wr_addr = target;
		wr_data = v_q;
		if (pend_q) begin
			wr_addr = pwa_q;
			wr_data = rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			v_q <= value;
		end
		if (cmd.place && mode_q == MODE_PIVOT) begin
			pivot_q <= v_q;
		end
		if (cmd.search_rd) begin
			mid_q <= mid;
		end
		if (cmd.shift_step) begin
			pwa_q <= (mode_q == MODE_FRONT) ? AW'(sptr_q[AW-1:0] - 1'b1)
			                                : AW'(sptr_q[AW-1:0] + 1'b1);
		end
		if (cmd.classify) begin
			if (is_front) begin
				lo_q <= {1'b0, fs_q};
				hi_q <= IW'(DEPTH - 1);
			end else begin
				lo_q <= '0;
				hi_q <= {1'b0, be_q};
			end
		end else if (cmd.search_cmp) begin
			if ($signed(rdata_q) <= $signed(v_q)) begin
				lo_q <= IW'(mid_q + 1'b1);
			end else begin
				hi_q <= IW'(mid_q - 1'b1);
			end
		end
		if (cmd.shift_init) begin
			sptr_q <= (mode_q == MODE_FRONT) ? {1'b0, fs_q} : {1'b0, be_q};
		end else if (cmd.shift_step) begin
			sptr_q <= (mode_q == MODE_FRONT) ? IW'(sptr_q + 1'b1) : IW'(sptr_q - 1'b1);
		end
		if (cmd.emit_init) begin
			eptr_q <= fs_q;
		end else if (cmd.emit_step) begin
			eptr_q <= (efront_q && eptr_q == AW'(DEPTH - 1)) ? '0 : AW'(eptr_q + 1'b1);
		end
		if (cmd.emit_step) begin
			out_end_s1 <= stat.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= 1'b0;
			mode_q     <= MODE_PIVOT;
			fs_q       <= '0;
			be_q       <= '0;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			pend_q     <= 1'b0;
			efront_q   <= 1'b0;
			out_vld_s1 <= 1'b0;
		end else begin
			pend_q     <= cmd.shift_step;
			out_vld_s1 <= cmd.emit_step;
			if (load) begin
				last_q <= last_item;
			end
			if (cmd.classify) begin
				if (cnt_q == '0) begin
					mode_q <= MODE_PIVOT;
				end else if (!is_front) begin
					mode_q <= MODE_BACK;
				end else if (fs_q == '0) begin
					mode_q <= MODE_FIRST;
				end else begin
					mode_q <= MODE_FRONT;
				end
				if (stat.full) begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.place) begin
				cnt_q <= IW'(cnt_q + 1'b1);
				unique case (mode_q)
					MODE_PIVOT: begin
						fs_q <= '0;
						be_q <= '0;
					end
					MODE_FIRST: fs_q <= AW'(DEPTH - 1);
					MODE_FRONT: fs_q <= AW'(fs_q - 1'b1);
					MODE_BACK:  be_q <= AW'(be_q + 1'b1);
					default:    be_q <= be_q;
				endcase
			end
			if (cmd.emit_init) begin
				efront_q <= fs_q != '0;
			end else if (cmd.emit_step && efront_q && eptr_q == AW'(DEPTH - 1)) begin
				efront_q <= 1'b0;
			end
			if (cmd.clear) begin
				cnt_q <= '0;
				fs_q  <= '0;
				be_q  <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	// no front region: emit starts at slot 0
	assign strobe       = out_vld_s1;
	assign sorted_value = rdata_q;
	assign end_of_run   = out_end_s1;
	assign overflow     = ovf_q;

endmodule

[rtl/twis_ctrl.sv]
// Controller of the two-way insertion sorter: sequences classify, search,
// shift, place and output phases. Depends on twis_pkg.
`timescale 1ns / 1ps

module twis_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            load,
	input  twis_pkg::stat_t stat,
	output twis_pkg::cmd_t  cmd
);
	import twis_pkg::*;

	localparam logic [3:0] ST_IDLE       = 4'd0;
	localparam logic [3:0] ST_CLASSIFY   = 4'd1;
	localparam logic [3:0] ST_SEARCH_ADR = 4'd2;
	localparam logic [3:0] ST_SEARCH_CMP = 4'd3;
	localparam logic [3:0] ST_SHIFT      = 4'd4;
	localparam logic [3:0] ST_FLUSH      = 4'd5;
	localparam logic [3:0] ST_PLACE      = 4'd6;
	localparam logic [3:0] ST_EMIT_SETUP = 4'd7;
	localparam logic [3:0] ST_EMIT       = 4'd8;
	localparam logic [3:0] ST_EMIT_END   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign busy = state_q != ST_IDLE;
	assign load = start && !busy;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = ST_CLASSIFY;
				end
			end
			ST_CLASSIFY: begin
				cmd.classify = 1'b1;
				if (stat.full) begin
					state_nxt = stat.last ? ST_EMIT_SETUP : ST_IDLE;
				end else if (stat.direct) begin
					state_nxt = ST_PLACE;
				end else begin
					state_nxt = ST_SEARCH_ADR;
				end
			end
			ST_SEARCH_ADR: begin
				if (stat.search_more) begin
					cmd.search_rd = 1'b1;
					state_nxt     = ST_SEARCH_CMP;
				end else begin
					cmd.shift_init = 1'b1;
					state_nxt      = ST_SHIFT;
				end
			end
			ST_SEARCH_CMP: begin
				cmd.search_cmp = 1'b1;
				state_nxt      = ST_SEARCH_ADR;
			end
			ST_SHIFT: begin
				if (stat.shift_more) begin
					cmd.shift_step = 1'b1;
				end else begin
					state_nxt = ST_FLUSH;
				end
			end
			// wait state before place; the last shifted word is already written in ST_SHIFT
			ST_FLUSH: begin
				state_nxt = ST_PLACE;
			end
			ST_PLACE: begin
				cmd.place = 1'b1;
				state_nxt = stat.last ? ST_EMIT_SETUP : ST_IDLE;
			end
			ST_EMIT_SETUP: begin
				cmd.emit_init = 1'b1;
				state_nxt     = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit_step = 1'b1;
				if (stat.emit_last) begin
					state_nxt = ST_EMIT_END;
				end
			end
			ST_EMIT_END: begin
				cmd.clear = 1'b1;
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[tb/two_way_insertion_sorter_unit_tb.sv]
// Self-checking testbench for two_way_insertion_sorter_unit.
// Sends sets of signed words and checks each streamed result against a
// local model of the two-region store. Depends only on the RTL.
`timescale 1ns / 1ps

module two_way_insertion_sorter_unit_tb;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDLE_LIMIT = 4000;
	localparam int TAIL_WAIT  = 150;
	localparam int RANDOM_ITEMS = 36;

	localparam logic [DATA_WIDTH-1:0] MAX_WORD = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] MIN_WORD = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	typedef enum int {
		MIX_RANDOM,
		MIX_NARROW,
		MIX_RISING,
		MIX_FALLING,
		MIX_EXTREME
	} value_mix_t;

	typedef struct {
		logic [DATA_WIDTH-1:0] word;
		logic                  eor;
		logic                  ovf;
	} sorted_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [DATA_WIDTH-1:0] value;
	logic                  last_item;
	logic                  strobe;
	logic [DATA_WIDTH-1:0] sorted_value;
	logic                  end_of_run;
	logic                  overflow;

	// local copy of the sorter state
	logic [DATA_WIDTH-1:0] slot_words [DEPTH];
	int                    front_head;
	int                    back_top;
	int                    held_words;
	logic                  dropped_any;

	sorted_word_t sorted_pending [$];

	int  mismatches;
	int  results_seen;
	int  sets_sent;
	int  words_sent;
	int  idle_cycles;
	bit  gaps_on;

	two_way_insertion_sorter_unit #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.last_item   (last_item),
		.strobe      (strobe),
		.sorted_value(sorted_value),
		.end_of_run  (end_of_run),
		.overflow    (overflow)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------- prediction ----------------

	task automatic insert_front(input logic [DATA_WIDTH-1:0] v);
		int lo;
		int hi;
		int mid;
		if (front_head == 0) begin
			slot_words[DEPTH-1] = v;
			front_head = DEPTH - 1;
			return;
		end
		lo = front_head;
		hi = DEPTH - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if ($signed(slot_words[mid]) <= $signed(v))
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		for (int j = front_head; j <= hi; j++)
			slot_words[j-1] = slot_words[j];
		slot_words[hi] = v;
		front_head--;
	endtask

	task automatic insert_back(input logic [DATA_WIDTH-1:0] v);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = back_top;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if ($signed(slot_words[mid]) <= $signed(v))
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		for (int j = back_top; j >= lo; j--)
			slot_words[j+1] = slot_words[j];
		slot_words[lo] = v;
		back_top++;
	endtask

	task automatic predict_sorted(input logic [DATA_WIDTH-1:0] v, input logic last);
		int total;
		int k;
		sorted_word_t r;
		if (held_words == 0) begin
			slot_words[0] = v;
			front_head = 0;
			back_top = 0;
			held_words = 1;
		end else if (held_words >= DEPTH) begin
			dropped_any = 1'b1;
		end else begin
			if ($signed(v) < $signed(slot_words[0]))
				insert_front(v);
			else
				insert_back(v);
			held_words++;
		end
		if (!last)
			return;
		total = back_top + 1 + ((front_head != 0) ? DEPTH - front_head : 0);
		k = 0;
		if (front_head != 0) begin
			for (int i = front_head; i < DEPTH; i++) begin
				r.word = slot_words[i];
				r.eor = (k == total - 1);
				r.ovf = dropped_any;
				sorted_pending.push_back(r);
				k++;
			end
		end
		for (int i = 0; i <= back_top; i++) begin
			r.word = slot_words[i];
			r.eor = (k == total - 1);
			r.ovf = dropped_any;
			sorted_pending.push_back(r);
			k++;
		end
		front_head = 0;
		back_top = 0;
		held_words = 0;
		dropped_any = 1'b0;
		sets_sent++;
	endtask

	// ---------------- driving ----------------

	// called at a falling edge; returns at a falling edge with start low
	task automatic send_word(input logic [DATA_WIDTH-1:0] v, input logic last);
		start = 1'b1;
		value = v;
		last_item = last;
		do
			@(posedge clk);
		while (busy);
		predict_sorted(v, last);
		words_sent++;
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic maybe_gap();
		if (gaps_on && $urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 12)) @(negedge clk);
	endtask

	task automatic wait_drained();
		while (sorted_pending.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [DATA_WIDTH-1:0] pick_value(input value_mix_t mix, input int k,
			input logic [DATA_WIDTH-1:0] base);
		case (mix)
			MIX_NARROW: begin
				return DATA_WIDTH'($signed($urandom_range(0, 8)) - 4);
			end
			MIX_RISING: begin
				return base + DATA_WIDTH'(k * 3);
			end
			MIX_FALLING: begin
				return base - DATA_WIDTH'(k * 3);
			end
			MIX_EXTREME: begin
				case ($urandom_range(0, 4))
					0: return MAX_WORD;
					1: return MIN_WORD;
					2: return '0;
					3: return '1;
					default: return DATA_WIDTH'($urandom);
				endcase
			end
			default: begin
				return DATA_WIDTH'($urandom);
			end
		endcase
	endfunction

	task automatic send_set(input int len, input value_mix_t mix);
		logic [DATA_WIDTH-1:0] base;
		base = DATA_WIDTH'($urandom_range(0, 32'h0fff_ffff)) - 32'h0800_0000;
		for (int k = 0; k < len; k++) begin
			send_word(pick_value(mix, k, base), k == len - 1);
			maybe_gap();
		end
	endtask

	// ---------------- checking ----------------

	task automatic report_mismatch(input string what, input sorted_word_t exp_w);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch (%s): expected value %0d eor %0b ovf %0b, got %0d eor %0b ovf %0b",
				$realtime, what, $signed(exp_w.word), exp_w.eor, exp_w.ovf,
				$signed(sorted_value), end_of_run, overflow);
	endtask

	always @(posedge clk) begin
		sorted_word_t exp_w;
		if (arst_n && strobe) begin
			results_seen++;
			if (sorted_pending.size() == 0) begin
				exp_w = '{word: 'x, eor: 1'bx, ovf: 1'bx};
				report_mismatch("unexpected word", exp_w);
			end else begin
				exp_w = sorted_pending.pop_front();
				if (sorted_value !== exp_w.word || end_of_run !== exp_w.eor ||
						overflow !== exp_w.ovf)
					report_mismatch("field", exp_w);
			end
		end
	end

	// cycles with neither an accepted input nor a result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// ---------------- tests ----------------

	task automatic test_lone_last();
		// last flag on an empty store: pivot comes straight back
		send_word(MIN_WORD, 1'b1);
		wait_drained();
		send_word(MAX_WORD, 1'b1);
		wait_drained();
	endtask

	task automatic test_extremes();
		send_word('0, 1'b0);
		send_word(MAX_WORD, 1'b0);
		send_word(MIN_WORD, 1'b0);
		send_word('1, 1'b0);
		send_word(32'd1, 1'b0);
		send_word('0, 1'b0);
		send_word(MIN_WORD, 1'b0);
		send_word(MAX_WORD, 1'b1);
		wait_drained();
	endtask

	task automatic test_duplicates();
		// equal words on both sides of the pivot, and equal to it
		send_word(32'd100, 1'b0);
		send_word(32'd100, 1'b0);
		send_word(32'd50, 1'b0);
		send_word(32'd50, 1'b0);
		send_word(32'd200, 1'b0);
		send_word(32'd50, 1'b0);
		send_word(32'd100, 1'b1);
		wait_drained();
	endtask

	task automatic test_full_and_overflow();
		// exactly full, no drop
		for (int k = 0; k < DEPTH; k++)
			send_word(DATA_WIDTH'($urandom), k == DEPTH - 1);
		wait_drained();
		// two dropped words, then a dropped word carrying the last flag
		for (int k = 0; k < DEPTH + 3; k++)
			send_word(pick_value(MIX_NARROW, k, '0), k == DEPTH + 2);
		wait_drained();
	endtask

	task automatic test_random_sets();
		int len;
		int start_count;
		value_mix_t mix;
		start_count = words_sent;
		gaps_on = 1'b1;
		while (words_sent - start_count < RANDOM_ITEMS) begin
			if (words_sent - start_count > RANDOM_ITEMS - 12)
				gaps_on = 1'b0;
			len = $urandom_range(1, 10);
			mix = value_mix_t'($urandom_range(0, 4));
			send_set(len, mix);
			if (gaps_on && $urandom_range(0, 3) == 0)
				wait_drained();
		end
		gaps_on = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		last_item = 1'b0;
		front_head = 0;
		back_top = 0;
		held_words = 0;
		dropped_any = 1'b0;
		mismatches = 0;
		results_seen = 0;
		sets_sent = 0;
		words_sent = 0;
		idle_cycles = 0;
		gaps_on = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_lone_last();
		test_extremes();
		test_duplicates();
		test_full_and_overflow();
		test_random_sets();

		wait_drained();
		repeat (TAIL_WAIT) @(negedge clk);

		$display("Sent %0d words in %0d sets (lone, extreme, duplicate, full, overflow, random).",
			words_sent, sets_sent);
		$display("Checked %0d sorted words, %0d mismatches.", results_seen, mismatches);
		if (mismatches == 0 && sorted_pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
